FILE: sv/fwq_pkg.sv
// ----------------------------------------------------------------------------
// fwq_pkg: shared types and codes of the futex wait queue engine
// Request and response payloads, command and status codes, cell control.
// ----------------------------------------------------------------------------
package fwq_pkg;

  localparam logic [3:0] FUNC_WAIT        = 4'd0;
  localparam logic [3:0] FUNC_WAKE        = 4'd1;
  localparam logic [3:0] FUNC_REQUEUE     = 4'd3;
  localparam logic [3:0] FUNC_CMP_REQUEUE = 4'd4;
  localparam logic [3:0] FUNC_WAIT_MASK   = 4'd9;
  localparam logic [3:0] FUNC_WAKE_MASK   = 4'd10;
  localparam logic [3:0] FUNC_CANCEL      = 4'd15;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_MISMATCH  = 3'd1;
  localparam logic [2:0] STATUS_BAD_MASK  = 3'd2;
  localparam logic [2:0] STATUS_UNSUPP    = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [3:0]         func;
    logic [21:0]        thread_id;
    logic [63:0]        wait_addr;
    logic [63:0]        second_addr;
    logic signed [31:0] value_arg;
    logic signed [31:0] extra_arg;
    logic               value_present;
    logic [63:0]        current_value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  woken_count;
    logic [6:0]  moved_count;
    logic        thread_waiting;
    logic [63:0] thread_wait_addr;
  } rsp_t;

  // One waiter; flg marks an entry bound for the tail during requeue.
  typedef struct packed {
    logic [21:0] thr;
    logic [63:0] adr;
    logic [31:0] msk;
    logic        flg;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_SORT,
    CELL_APPEND
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     keep;
    logic     phase;
    entry_t   head;
    entry_t   fresh;
  } cell_ctl_t;

endpackage

FILE: sv/fwq_cell.sv
// ----------------------------------------------------------------------------
// fwq_cell: one slot of the waiter chain
// Shifts towards the head, takes the recirculated head at the tail, takes a
// new entry on append, and swaps with a neighbour in odd-even sort steps.
// ----------------------------------------------------------------------------
module fwq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic               clk_i,
  input  fwq_pkg::cell_ctl_t ctl_i,
  input  logic [CW-1:0]      count_i,
  input  fwq_pkg::entry_t    left_i,
  input  fwq_pkg::entry_t    right_i,
  output fwq_pkg::entry_t    q_o
);

  localparam logic ODD = 1'(IDX % 2);

  fwq_pkg::entry_t slot_q, slot_d;
  logic is_tail, is_free, in_range, right_in_range;

  assign is_tail        = (CW'(IDX) + CW'(1)) == count_i;
  assign is_free        = CW'(IDX) == count_i;
  assign in_range       = CW'(IDX) < count_i;
  assign right_in_range = (CW'(IDX) + CW'(1)) < count_i;

  always_comb begin
    slot_d = slot_q;
    case (ctl_i.op)
      fwq_pkg::CELL_SHIFT: begin
        slot_d = (ctl_i.keep && is_tail) ? ctl_i.head : right_i;
      end
      fwq_pkg::CELL_APPEND: begin
        if (is_free) slot_d = ctl_i.fresh;
      end
      fwq_pkg::CELL_SORT: begin
        if (ODD == ctl_i.phase) begin
          // left of pair: hand a flagged entry rightwards
          if (slot_q.flg && !right_i.flg && right_in_range) slot_d = right_i;
        end else if (IDX > 0) begin
          if (left_i.flg && !slot_q.flg && in_range) slot_d = left_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign q_o = slot_q;

endmodule

FILE: sv/futex_wait_queue_engine_top.sv
// ----------------------------------------------------------------------------
// futex_wait_queue_engine_top: futex wait queue with bitset and requeue
// Bounded table of waiting threads held in arrival order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: present a request on req_i with start high while busy is low; it is
// taken at that clock edge. One response per request appears on rsp_o with
// done_o high for exactly one cycle; the receiver cannot hold it off.
// Rejected requests (bad mask, value mismatch, unsupported) go straight to the
// report pass; a requeue also runs the odd-even sort over all N cells
// (N = MAX_WAITERS). Each scan pass walks the head cell once round the chain
// per queued waiter, one entry per cycle.
// busy stays high until the response is shown; the next request may be
// taken in the cycle the response is shown.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module futex_wait_queue_engine_top #(
  parameter int MAX_WAITERS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fwq_pkg::req_t req_i,
  output logic          done_o,
  output fwq_pkg::rsp_t rsp_o
);

  localparam int CW = $clog2(MAX_WAITERS + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DROP, ST_APPEND, ST_WAKE, ST_MARK, ST_SORT, ST_REPORT
  } state_e;

  state_e            st_q;
  fwq_pkg::req_t     req_q;
  fwq_pkg::rsp_t     rsp_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q, rem_q, hits_q, moved_q, sort_n_q;
  logic [2:0]        status_q;
  logic              found_q, dropped_q, phase_q;
  logic [63:0]       rep_adr_q;

  fwq_pkg::entry_t   cq [MAX_WAITERS];
  fwq_pkg::entry_t   head;
  fwq_pkg::cell_ctl_t ctl;

  logic [31:0] wmask, smask, lim1, lim2;
  logic        wake_hit, mark_hit, tid_hit, scan_go, is_requeue, mismatch;
  logic        full;

  assign head       = cq[0];
  assign scan_go    = rem_q != '0;
  assign wmask      = (req_q.func == fwq_pkg::FUNC_WAKE_MASK) ? req_q.extra_arg : '1;
  assign smask      = (req_q.func == fwq_pkg::FUNC_WAIT_MASK) ? req_q.extra_arg : '1;
  assign lim1       = req_q.value_arg[31] ? '0 : {1'b0, req_q.value_arg[30:0]};
  assign lim2       = req_q.extra_arg[31] ? '0 : {1'b0, req_q.extra_arg[30:0]};
  assign wake_hit   = (head.adr == req_q.wait_addr) && (|(head.msk & wmask))
                      && (32'(hits_q) < lim1);
  assign mark_hit   = (head.adr == req_q.wait_addr) && (32'(moved_q) < lim2);
  assign tid_hit    = head.thr == req_q.thread_id;
  assign is_requeue = (req_q.func == fwq_pkg::FUNC_REQUEUE)
                      || (req_q.func == fwq_pkg::FUNC_CMP_REQUEUE);
  assign mismatch   = req_i.value_present
                      && (req_i.current_value != {{32{req_i.value_arg[31]}}, req_i.value_arg});
  assign full       = cnt_q == CW'(MAX_WAITERS);

  always_comb begin
    ctl       = '0;
    ctl.op    = fwq_pkg::CELL_HOLD;
    ctl.keep  = 1'b1;
    ctl.phase = phase_q;
    ctl.head  = head;
    ctl.fresh = '{thr: req_q.thread_id, adr: req_q.wait_addr, msk: smask, flg: 1'b0};
    case (st_q)
      ST_DROP: begin
        if (scan_go) begin
          ctl.op   = fwq_pkg::CELL_SHIFT;
          ctl.keep = !tid_hit;
        end
      end
      ST_WAKE: begin
        if (scan_go) begin
          ctl.op   = fwq_pkg::CELL_SHIFT;
          ctl.keep = !wake_hit;
        end
      end
      ST_MARK: begin
        if (scan_go) begin
          ctl.op = fwq_pkg::CELL_SHIFT;
          if (mark_hit) begin
            ctl.head.adr = req_q.second_addr;
            ctl.head.flg = 1'b1;
          end
        end
      end
      ST_SORT:   ctl.op = fwq_pkg::CELL_SORT;
      ST_APPEND: begin
        if (!full) ctl.op = fwq_pkg::CELL_APPEND;
      end
      ST_REPORT: begin
        if (scan_go) begin
          ctl.op       = fwq_pkg::CELL_SHIFT;
          ctl.head.flg = 1'b0;
        end
      end
      default: ctl.op = fwq_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    fwq_pkg::entry_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cq[i-1];
    end
    if (i == MAX_WAITERS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cq[i+1];
    end
    fwq_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .count_i (cnt_q),
      .left_i  (left_w),
      .right_i (right_w),
      .q_o     (cq[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && start) req_q <= req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      rem_q     <= '0;
      hits_q    <= '0;
      moved_q   <= '0;
      sort_n_q  <= '0;
      status_q  <= fwq_pkg::STATUS_OK;
      found_q   <= 1'b0;
      dropped_q <= 1'b0;
      phase_q   <= 1'b0;
      rep_adr_q <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (start) begin
            hits_q    <= '0;
            moved_q   <= '0;
            found_q   <= 1'b0;
            dropped_q <= 1'b0;
            rep_adr_q <= '0;
            rem_q     <= cnt_q;
            status_q  <= fwq_pkg::STATUS_OK;
            case (req_i.func)
              fwq_pkg::FUNC_WAIT, fwq_pkg::FUNC_WAIT_MASK: begin
                if (req_i.func == fwq_pkg::FUNC_WAIT_MASK && req_i.extra_arg == '0) begin
                  status_q <= fwq_pkg::STATUS_BAD_MASK;
                  st_q     <= ST_REPORT;
                end else if (mismatch) begin
                  status_q <= fwq_pkg::STATUS_MISMATCH;
                  st_q     <= ST_REPORT;
                end else begin
                  st_q <= ST_DROP;
                end
              end
              fwq_pkg::FUNC_WAKE_MASK: begin
                if (req_i.extra_arg == '0) begin
                  status_q <= fwq_pkg::STATUS_BAD_MASK;
                  st_q     <= ST_REPORT;
                end else begin
                  st_q <= ST_WAKE;
                end
              end
              fwq_pkg::FUNC_WAKE, fwq_pkg::FUNC_REQUEUE,
              fwq_pkg::FUNC_CMP_REQUEUE: st_q <= ST_WAKE;
              fwq_pkg::FUNC_CANCEL:      st_q <= ST_DROP;
              default: begin
                status_q <= fwq_pkg::STATUS_UNSUPP;
                st_q     <= ST_REPORT;
              end
            endcase
          end
        end
        ST_DROP: begin
          if (scan_go) begin
            rem_q <= rem_q - CW'(1);
            if (tid_hit) begin
              cnt_q     <= cnt_q - CW'(1);
              dropped_q <= 1'b1;
            end
          end else if (req_q.func == fwq_pkg::FUNC_CANCEL) begin
            if (!dropped_q) status_q <= fwq_pkg::STATUS_NOT_FOUND;
            rem_q <= cnt_q;
            st_q  <= ST_REPORT;
          end else begin
            st_q <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          if (full) begin
            status_q <= fwq_pkg::STATUS_FULL;
            rem_q    <= cnt_q;
          end else begin
            cnt_q <= cnt_q + CW'(1);
            rem_q <= cnt_q + CW'(1);
          end
          st_q <= ST_REPORT;
        end
        ST_WAKE: begin
          if (scan_go) begin
            rem_q <= rem_q - CW'(1);
            if (wake_hit) begin
              cnt_q  <= cnt_q - CW'(1);
              hits_q <= hits_q + CW'(1);
            end
          end else begin
            rem_q <= cnt_q;
            st_q  <= is_requeue ? ST_MARK : ST_REPORT;
          end
        end
        ST_MARK: begin
          if (scan_go) begin
            rem_q <= rem_q - CW'(1);
            if (mark_hit) moved_q <= moved_q + CW'(1);
          end else begin
            sort_n_q <= '0;
            phase_q  <= 1'b0;
            st_q     <= ST_SORT;
          end
        end
        ST_SORT: begin
          // settle flagged entries behind the rest, order kept
          phase_q  <= ~phase_q;
          sort_n_q <= sort_n_q + CW'(1);
          if (sort_n_q == CW'(MAX_WAITERS - 1)) begin
            rem_q <= cnt_q;
            st_q  <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (scan_go) begin
            rem_q <= rem_q - CW'(1);
            if (tid_hit && !found_q) begin
              found_q   <= 1'b1;
              rep_adr_q <= head.adr;
            end
          end else begin
            done_q                 <= 1'b1;
            rsp_q.status           <= status_q;
            rsp_q.woken_count      <= 7'(hits_q);
            rsp_q.moved_count      <= 7'(moved_q);
            rsp_q.thread_waiting   <= found_q;
            rsp_q.thread_wait_addr <= rep_adr_q;
            st_q                   <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = st_q != ST_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

FILE: sim/fwq_checker.sv
// ----------------------------------------------------------------------------
// fwq_checker: response checker for the futex wait queue engine
// Mirrors the waiter table, predicts one response per accepted request and
// compares it as a whole with the response shown by the engine.
// ----------------------------------------------------------------------------
module fwq_checker #(
  parameter int MAX_WAITERS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  fwq_pkg::req_t req_i,
  input  logic          done_i,
  input  fwq_pkg::rsp_t rsp_i,
  output int            err_cnt_o,
  output int            pending_o
);

  typedef struct {
    logic [21:0] thr;
    logic [63:0] adr;
    logic [31:0] msk;
  } waiter_t;

  waiter_t       waiters[$];
  fwq_pkg::rsp_t rsp_expected_q[$];

  assign pending_o = rsp_expected_q.size();

  function automatic int find_waiter(logic [21:0] thr);
    foreach (waiters[i]) if (waiters[i].thr == thr) return i;
    return -1;
  endfunction

  function automatic int unsigned count_of(logic [31:0] v);
    return v[31] ? 0 : v;
  endfunction

  function automatic int unsigned wake_waiters(logic [63:0] adr, int unsigned lim,
                                               logic [31:0] msk);
    waiter_t     kept[$];
    int unsigned woken;
    woken = 0;
    foreach (waiters[i]) begin
      if (woken < lim && waiters[i].adr == adr && (waiters[i].msk & msk) != 0)
        woken++;
      else
        kept = {kept, waiters[i]};
    end
    waiters = kept;
    return woken;
  endfunction

  function automatic int unsigned move_waiters(logic [63:0] adr, logic [63:0] adr2,
                                               int unsigned lim);
    waiter_t     kept[$];
    waiter_t     moved_q[$];
    waiter_t     w;
    kept = {};
    foreach (waiters[i]) begin
      if (moved_q.size() < lim && waiters[i].adr == adr) begin
        w = waiters[i];
        w.adr = adr2;
        moved_q = {moved_q, w};
      end else begin
        kept = {kept, waiters[i]};
      end
    end
    waiters = {kept, moved_q};
    return moved_q.size();
  endfunction

  function automatic logic [2:0] enqueue_waiter(fwq_pkg::req_t r, logic [31:0] msk);
    int      idx;
    waiter_t w;
    if (r.value_present && r.current_value != {{32{r.value_arg[31]}}, r.value_arg})
      return fwq_pkg::STATUS_MISMATCH;
    idx = find_waiter(r.thread_id);
    if (idx >= 0) waiters.delete(idx);
    if (waiters.size() >= MAX_WAITERS) return fwq_pkg::STATUS_FULL;
    w.thr = r.thread_id;
    w.adr = r.wait_addr;
    w.msk = msk;
    waiters = {waiters, w};
    return fwq_pkg::STATUS_OK;
  endfunction

  function automatic fwq_pkg::rsp_t predict_response(fwq_pkg::req_t r);
    fwq_pkg::rsp_t p;
    int            idx;
    p = '0;
    case (r.func)
      fwq_pkg::FUNC_WAIT: p.status = enqueue_waiter(r, 32'hFFFF_FFFF);
      fwq_pkg::FUNC_WAIT_MASK: begin
        if (r.extra_arg == 0) p.status = fwq_pkg::STATUS_BAD_MASK;
        else p.status = enqueue_waiter(r, r.extra_arg);
      end
      fwq_pkg::FUNC_WAKE:
        p.woken_count = 7'(wake_waiters(r.wait_addr, count_of(r.value_arg),
                                        32'hFFFF_FFFF));
      fwq_pkg::FUNC_WAKE_MASK: begin
        if (r.extra_arg == 0) p.status = fwq_pkg::STATUS_BAD_MASK;
        else p.woken_count = 7'(wake_waiters(r.wait_addr, count_of(r.value_arg),
                                             r.extra_arg));
      end
      fwq_pkg::FUNC_REQUEUE, fwq_pkg::FUNC_CMP_REQUEUE: begin
        p.woken_count = 7'(wake_waiters(r.wait_addr, count_of(r.value_arg),
                                        32'hFFFF_FFFF));
        p.moved_count = 7'(move_waiters(r.wait_addr, r.second_addr,
                                        count_of(r.extra_arg)));
      end
      fwq_pkg::FUNC_CANCEL: begin
        idx = find_waiter(r.thread_id);
        if (idx < 0) p.status = fwq_pkg::STATUS_NOT_FOUND;
        else waiters.delete(idx);
      end
      default: p.status = fwq_pkg::STATUS_UNSUPP;
    endcase
    idx = find_waiter(r.thread_id);
    if (idx >= 0) begin
      p.thread_waiting   = 1'b1;
      p.thread_wait_addr = waiters[idx].adr;
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fwq_pkg::rsp_t e;
    if (!rst_ni) begin
      waiters = {};
      rsp_expected_q = {};
      err_cnt_o <= 0;
    end else begin
      // Take the response first: a new request may be accepted in the same cycle.
      if (done_i) begin
        if (rsp_expected_q.size() == 0) begin
          if (err_cnt_o < 10) $display("unexpected response %p", rsp_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          e = rsp_expected_q.pop_front();
          if (e !== rsp_i) begin
            if (err_cnt_o < 10) $display("mismatch: expected %p, got %p", e, rsp_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (start_i && !busy_i) rsp_expected_q = {rsp_expected_q, predict_response(req_i)};
    end
  end

endmodule

FILE: sim/futex_wait_queue_engine_top_tb.sv
// ----------------------------------------------------------------------------
// futex_wait_queue_engine_top_tb: testbench of the futex wait queue engine
// Directed corners, then random traffic of all commands and unused codes over
// pooled addresses, small or wide thread ranges and varying request gaps.
// ----------------------------------------------------------------------------
module futex_wait_queue_engine_top_tb;

  localparam int MAX_WAITERS = 64;
  localparam int REQ_W       = $bits(fwq_pkg::req_t);

  // Codes outside the supported command set.
  localparam logic [3:0] FUNC_UNUSED_LO = 4'd2;
  localparam logic [3:0] FUNC_UNUSED_HI = 4'd14;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  fwq_pkg::req_t req = '0;
  logic          done_o;
  fwq_pkg::rsp_t rsp;
  int            err_cnt;
  int            pending;
  int            gap_pct = 0;

  logic [63:0] addr_pool[4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'h0000_7FFF_1234_5678, 64'h8000_0000_0000_1000};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  futex_wait_queue_engine_top #(.MAX_WAITERS(MAX_WAITERS)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp)
  );

  fwq_checker #(.MAX_WAITERS(MAX_WAITERS)) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .req_i     (req),
    .done_i    (done_o),
    .rsp_i     (rsp),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  // Present one request, hold it until taken, then idle at random.
  task automatic send_request(fwq_pkg::req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      req   <= REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom});
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
      @(posedge clk_i);
    end
  endtask

  function automatic fwq_pkg::req_t random_request(int unsigned n_thr);
    fwq_pkg::req_t r;
    int            k;
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom});
    r.thread_id = 22'((n_thr > 70) ? $urandom : $urandom_range(n_thr - 1));
    if ($urandom_range(3) != 0) r.thread_id[21] = 1'($urandom_range(1));
    if ($urandom_range(9) != 0) r.wait_addr = addr_pool[$urandom_range(3)];
    if ($urandom_range(9) != 0) r.second_addr = addr_pool[$urandom_range(3)];
    k = $urandom_range(99);
    if (k < 40) r.func = $urandom_range(1) ? fwq_pkg::FUNC_WAIT : fwq_pkg::FUNC_WAIT_MASK;
    else if (k < 60)
      r.func = $urandom_range(1) ? fwq_pkg::FUNC_WAKE : fwq_pkg::FUNC_WAKE_MASK;
    else if (k < 75)
      r.func = $urandom_range(1) ? fwq_pkg::FUNC_REQUEUE : fwq_pkg::FUNC_CMP_REQUEUE;
    else if (k < 90) r.func = fwq_pkg::FUNC_CANCEL;
    if ($urandom_range(3) != 0) r.value_arg = $urandom_range(4);
    if ($urandom_range(3) != 0) r.extra_arg = (r.func == fwq_pkg::FUNC_REQUEUE ||
        r.func == fwq_pkg::FUNC_CMP_REQUEUE) ? $urandom_range(4) : (1 << $urandom_range(31));
    if ($urandom_range(9) == 0) r.extra_arg = 0;
    if ($urandom_range(2) != 0)
      r.current_value = {{32{r.value_arg[31]}}, r.value_arg};
    return r;
  endfunction

  function automatic fwq_pkg::req_t mk(logic [3:0] f, logic [21:0] t, logic [63:0] a,
                                       logic [63:0] a2, logic [31:0] v, logic [31:0] x,
                                       logic p, logic [63:0] c);
    fwq_pkg::req_t r;
    r = '{f, t, a, a2, v, x, p, c};
    return r;
  endfunction

  initial begin
    #4000000;
    $display("futex_wait_queue_engine_top_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed corners.
    send_request(mk(fwq_pkg::FUNC_WAIT, 22'h3FFFFF, '1, '0, 32'h8000_0000, 0, 1'b1,
                    64'hFFFF_FFFF_8000_0000));
    send_request(mk(fwq_pkg::FUNC_WAIT, 22'd0, '0, '0, 32'h7FFF_FFFF, 0, 1'b1,
                    64'h7FFF_FFFF));
    send_request(mk(fwq_pkg::FUNC_WAIT, 22'd1, '0, '0, 32'hFFFF_FFFF, 0, 1'b1,
                    64'hFFFF_FFFF));
    send_request(mk(fwq_pkg::FUNC_WAIT_MASK, 22'd2, '0, '0, 0, 32'h0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAIT_MASK, 22'd2, '0, '0, 0, 32'h8000_0000, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAIT_MASK, 22'd3, '0, '0, 0, 32'h1, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAIT, 22'd0, '1, '0, 0, 0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAKE_MASK, 22'd3, '0, '0, 5, 32'h0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAKE_MASK, 22'd3, '0, '0, 5, 32'h2, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAKE_MASK, 22'd3, '0, '0, 1, 32'h8000_0001, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAKE, 22'd1, '0, '0, 32'h8000_0000, 0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_REQUEUE, 22'd3, '0, '0, 0, 32'h7FFF_FFFF, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_CMP_REQUEUE, 22'd3, '0, '1, 1, 32'h8000_0000, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_REQUEUE, 22'd3, '1, '0, 0, 1, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_CANCEL, 22'd0, '0, '0, 0, 0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_CANCEL, 22'd0, '0, '0, 0, 0, 1'b0, 0));
    send_request(mk(FUNC_UNUSED_LO, 22'd1, '0, '0, 0, 0, 1'b0, 0));
    send_request(mk(FUNC_UNUSED_HI, 22'd1, '0, '0, 0, 0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAKE, 22'd1, '1, '0, 32'h7FFF_FFFF, 0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAKE, 22'd1, '0, '0, 32'h7FFF_FFFF, 0, 1'b0, 0));
    // Fill the table past its limit, then drain it.
    for (int i = 0; i < MAX_WAITERS + 2; i++)
      send_request(mk(fwq_pkg::FUNC_WAIT, 22'(i + 100), addr_pool[i % 4], '0, 0, 0,
                      1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_WAIT, 22'd101, '1, '0, 0, 0, 1'b0, 0));
    send_request(mk(fwq_pkg::FUNC_REQUEUE, 22'd101, '1, '0, 2, 64, 1'b0, 0));
    for (int i = 0; i < 4; i++)
      send_request(mk(fwq_pkg::FUNC_WAKE, 22'd0, addr_pool[i], '0, 64, 0, 1'b0, 0));
    // Random traffic over several idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 84 : (ph == 3) ? 32 : 0;
      for (int i = 0; i < 100; i++) begin
        n = (ph == 2) ? 90 : 24;
        send_request(random_request(n));
      end
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0)
      $display("futex_wait_queue_engine_top_tb: done, clean");
    else
      $display("futex_wait_queue_engine_top_tb: done, errors");
    $finish;
  end

endmodule
